// ===== hdl/csfw_pkg.sv =====
package csfw_pkg;

  localparam int QUEUE_DEPTH_DEF    = 16;
  localparam int THREAD_ID_BITS_DEF = 8;

  localparam logic OP_WAIT   = 1'b0;
  localparam logic OP_SIGNAL = 1'b1;

  localparam logic [2:0] KIND_ACQUIRED   = 3'd0;
  localparam logic [2:0] KIND_QUEUED     = 3'd1;
  localparam logic [2:0] KIND_FULL       = 3'd2;
  localparam logic [2:0] KIND_WOKEN      = 3'd3;
  localparam logic [2:0] KIND_WOKE_NONE  = 3'd4;

  typedef struct packed {
    logic        command;
    logic [7:0]  thread_id;
    logic [31:0] release_count;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  woken_thread;
    logic [4:0]  released_total;
    logic [31:0] count_after;
    logic        count_saturated;
    logic        last;
  } out_item_t;

  // An item after classification by the front end.
  typedef struct packed {
    logic        op;
    logic [7:0]  tid;
    logic [31:0] rc;
    logic        rc_zero;
  } cls_item_t;

endpackage

// ===== hdl/csfw_front.sv =====
module csfw_front
  import csfw_pkg::*;
#(
  parameter int THREAD_ID_BITS = THREAD_ID_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      push,
  output cls_item_t push_item,
  input  logic      q_full
);

  localparam logic [7:0] TID_MASK = 8'((1 << THREAD_ID_BITS) - 1);

  logic      fr_valid_r;
  logic      fr_valid_nxt;
  cls_item_t fr_item_r;
  logic      take;

  assign in_stall  = fr_valid_r && q_full;
  assign push      = fr_valid_r && !q_full;
  assign push_item = fr_item_r;
  assign take      = in_valid && !in_stall;

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (push) begin
      fr_valid_nxt = 1'b0;
    end
    if (take) begin
      fr_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fr_item_r.op      <= in_item.command;
      fr_item_r.tid     <= in_item.thread_id & TID_MASK;
      fr_item_r.rc      <= in_item.release_count;
      fr_item_r.rc_zero <= (in_item.release_count == 32'd0);
    end
  end

endmodule

// ===== hdl/csfw_queue.sv =====
module csfw_queue
  import csfw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cls_item_t push_item,
  output logic      q_full,
  input  logic      pop,
  output logic      q_valid,
  output cls_item_t q_item
);

  cls_item_t  ent_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign q_full  = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hdl/csfw_back.sv =====
module csfw_back
  import csfw_pkg::*;
#(
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
  parameter int THREAD_ID_BITS = THREAD_ID_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  cls_item_t   q_item,
  output logic        pop,
  input  logic        cfg_write_en,
  input  logic [31:0] cfg_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item
);

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MIN  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_NONE = 3'd3;
  localparam logic [2:0] S_READ = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [31:0]         count_r, count_nxt;
  logic                sat_r, sat_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [PTR_W-1:0]    head_r, head_nxt;
  logic [PTR_W-1:0]    tail_r, tail_nxt;
  logic [31:0]         rc_r, rc_nxt;
  logic [31:0]         rest_r, rest_nxt;
  logic [FILL_W-1:0]   woken_r, woken_nxt;
  logic [FILL_W-1:0]   rem_r, rem_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_r, out_nxt;
  logic [THREAD_ID_BITS-1:0] mem [QUEUE_DEPTH];
  logic [THREAD_ID_BITS-1:0] rd_r;
  logic                mem_we;
  logic                out_free;
  logic [31:0]         fill_ext;
  logic                rc_below;
  logic [32:0]         sum;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign fill_ext  = 32'(fill_r);
  assign rc_below  = (rc_r < fill_ext);
  assign sum       = {1'b0, count_r} + {1'b0, rest_r};

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    sat_nxt       = sat_r;
    fill_nxt      = fill_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    rc_nxt        = rc_r;
    rest_nxt      = rest_r;
    woken_nxt     = woken_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    pop           = 1'b0;
    mem_we        = 1'b0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          pop = 1'b1;
          if (q_item.op == OP_WAIT) begin
            out_valid_nxt           = 1'b1;
            out_nxt.woken_thread    = 8'd0;
            out_nxt.released_total  = 5'd0;
            out_nxt.count_saturated = 1'b0;
            out_nxt.last            = 1'b1;
            out_nxt.count_after     = count_r;
            if (count_r != 32'd0) begin
              count_nxt           = count_r - 32'd1;
              out_nxt.kind        = KIND_ACQUIRED;
              out_nxt.count_after = count_r - 32'd1;
            end else if (fill_r < FILL_W'(QUEUE_DEPTH)) begin
              mem_we       = 1'b1;
              tail_nxt     = next_slot(tail_r);
              fill_nxt     = fill_r + FILL_W'(1);
              out_nxt.kind = KIND_QUEUED;
            end else begin
              out_nxt.kind = KIND_FULL;
            end
          end else begin
            rc_nxt = q_item.rc;
            if (q_item.rc_zero) begin
              woken_nxt = '0;
              rem_nxt   = '0;
              rest_nxt  = 32'd0;
              state_nxt = S_SUM;
            end else begin
              state_nxt = S_MIN;
            end
          end
        end
      end
      S_MIN: begin
        woken_nxt = rc_below ? FILL_W'(rc_r) : fill_r;
        rem_nxt   = rc_below ? FILL_W'(rc_r) : fill_r;
        rest_nxt  = rc_r - (rc_below ? rc_r : fill_ext);
        state_nxt = S_SUM;
      end
      S_SUM: begin
        if (sum[32]) begin
          count_nxt = '1;
          sat_nxt   = 1'b1;
        end else begin
          count_nxt = sum[31:0];
          sat_nxt   = 1'b0;
        end
        state_nxt = (woken_r == '0) ? S_NONE : S_READ;
      end
      S_NONE: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_nxt.kind            = KIND_WOKE_NONE;
          out_nxt.woken_thread    = 8'd0;
          out_nxt.released_total  = 5'd0;
          out_nxt.count_after     = count_r;
          out_nxt.count_saturated = sat_r;
          out_nxt.last            = 1'b1;
          state_nxt               = S_IDLE;
        end
      end
      S_READ: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_nxt.kind            = KIND_WOKEN;
          out_nxt.woken_thread    = 8'(rd_r);
          out_nxt.released_total  = 5'(woken_r);
          out_nxt.count_after     = count_r;
          out_nxt.count_saturated = sat_r;
          out_nxt.last            = (rem_r == FILL_W'(1));
          head_nxt                = next_slot(head_r);
          fill_nxt                = fill_r - FILL_W'(1);
          rem_nxt                 = rem_r - FILL_W'(1);
          state_nxt               = (rem_r == FILL_W'(1)) ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cfg_write_en) begin
      count_nxt = cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= 32'd0;
      sat_r       <= 1'b0;
      fill_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      rem_r       <= '0;
      woken_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sat_r       <= sat_nxt;
      fill_r      <= fill_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      rem_r       <= rem_nxt;
      woken_r     <= woken_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rc_r   <= rc_nxt;
    rest_r <= rest_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail_r] <= THREAD_ID_BITS'(q_item.tid);
    end
    rd_r <= mem[head_r];
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(QUEUE_DEPTH))
    else $error("waiter fill exceeds queue depth");

  a_emit_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT || state_r == S_READ) |-> (rem_r != '0 && rem_r <= fill_r))
    else $error("wake loop with no waiter left to release");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == S_IDLE && q_valid))
    else $error("item taken from queue while busy");

  a_woken_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_free && rem_r == FILL_W'(1)) |=>
      (out_valid_r && out_r.last && state_r == S_IDLE))
    else $error("final wake result not marked last");

endmodule

// ===== hdl/counting_semaphore_fifo_waiters_top.sv =====
// Wait items: the result is registered once the item has passed the front register and the input
// queue; waits sustain one item per cycle when the result side does not stall.
// Signal items: the back end steps through the min, sum, read and emit states before the first
// result; each further woken waiter takes read and emit again, as the memory read is registered.
// A signal that wakes nobody answers from the none state; a zero release count skips min.
// Reset (synchronous, rst_n low) zeroes the count and empties both queues, not the waiter memory.
module counting_semaphore_fifo_waiters_top
  import csfw_pkg::*;
#(
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
  parameter int THREAD_ID_BITS = THREAD_ID_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_write_en,
  input  logic [31:0] cfg_write_data
);

  logic      push;
  cls_item_t push_item;
  logic      q_full;
  logic      q_valid;
  cls_item_t q_item;
  logic      pop;

  csfw_front #(
    .THREAD_ID_BITS(THREAD_ID_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  csfw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  csfw_back #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .THREAD_ID_BITS (THREAD_ID_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .pop            (pop),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item)
  );

endmodule

// ===== tb/sv/semaphore_checker.sv =====
`timescale 1ns / 1ps

module semaphore_checker
  import csfw_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_item,
  input  logic        cfg_write_en,
  input  logic [31:0] cfg_write_data,
  output int          fail_count,
  output int          replies_due
);

  logic [31:0] sem_level;
  logic [7:0]  waiter_ids [QUEUE_DEPTH];
  int          wq_head;
  int          wq_tail;
  int          wq_fill;
  int          errors = 0;
  out_item_t   expected_replies [$];

  function automatic void predict_semaphore_item(input in_item_t it);
    out_item_t   reply;
    logic [31:0] rest;
    logic [32:0] sum;
    logic        sat;
    int          woken;
    reply = '0;
    reply.last = 1'b1;
    if (it.command == OP_WAIT) begin
      if (sem_level != 32'd0) begin
        sem_level = sem_level - 32'd1;
        reply.kind = KIND_ACQUIRED;
      end else if (wq_fill < QUEUE_DEPTH) begin
        waiter_ids[wq_tail] = it.thread_id;
        wq_tail = (wq_tail + 1) % QUEUE_DEPTH;
        wq_fill++;
        reply.kind = KIND_QUEUED;
      end else begin
        reply.kind = KIND_FULL;
      end
      reply.count_after = sem_level;
      expected_replies.push_back(reply);
    end else begin
      woken = (it.release_count < 32'(wq_fill)) ? int'(it.release_count) : wq_fill;
      rest = it.release_count - 32'(woken);
      sum = {1'b0, sem_level} + {1'b0, rest};
      sat = sum[32];
      sem_level = sat ? 32'hFFFF_FFFF : sum[31:0];
      reply.count_after = sem_level;
      reply.count_saturated = sat;
      if (woken == 0) begin
        reply.kind = KIND_WOKE_NONE;
        expected_replies.push_back(reply);
      end else begin
        reply.kind = KIND_WOKEN;
        reply.released_total = 5'(woken);
        for (int i = 0; i < woken; i++) begin
          reply.woken_thread = waiter_ids[wq_head];
          reply.last = (i == woken - 1);
          wq_head = (wq_head + 1) % QUEUE_DEPTH;
          wq_fill--;
          expected_replies.push_back(reply);
        end
      end
    end
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      sem_level = 32'd0;
      wq_head = 0;
      wq_tail = 0;
      wq_fill = 0;
      expected_replies.delete();
    end else begin
      if (cfg_write_en) begin
        sem_level = cfg_write_data;
      end
      if (in_valid && !in_stall) begin
        predict_semaphore_item(in_item);
      end
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected item, expected none, got %0h", $time, out_item);
          errors++;
        end else begin
          want = expected_replies.pop_front();
          compare_field("kind", 32'(want.kind), 32'(out_item.kind));
          compare_field("woken_thread", 32'(want.woken_thread), 32'(out_item.woken_thread));
          compare_field("released_total", 32'(want.released_total),
                        32'(out_item.released_total));
          compare_field("count_after", want.count_after, out_item.count_after);
          compare_field("count_saturated", 32'(want.count_saturated),
                        32'(out_item.count_saturated));
          compare_field("last", 32'(want.last), 32'(out_item.last));
        end
      end
    end
    fail_count <= errors;
    replies_due <= expected_replies.size();
  end

endmodule

// ===== tb/sv/tb_counting_semaphore_fifo_waiters_top.sv =====
`timescale 1ns / 1ps

module tb_counting_semaphore_fifo_waiters_top;
  import csfw_pkg::*;

  localparam int RUN_LIMIT    = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_write_en = 1'b0;
  logic [31:0] cfg_write_data = 32'd0;

  int fail_count;
  int replies_outstanding;
  int sent_items = 0;
  int cycle_count = 0;
  int rx_cycles;
  int hold_left;
  bit hold_done;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  counting_semaphore_fifo_waiters_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  semaphore_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .fail_count     (fail_count),
    .replies_due    (replies_outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_cycles <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      rx_cycles <= rx_cycles + 1;
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && sent_items >= 260) begin
        out_stall <= 1'b1;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (rx_cycles >= 1500 && rx_cycles < 2100) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 25);
      end
    end
  end

  function automatic in_item_t make_item(input logic cmd, input logic [7:0] tid,
                                         input logic [31:0] rc);
    in_item_t it;
    it.command = cmd;
    it.thread_id = tid;
    it.release_count = rc;
    return it;
  endfunction

  // Waits outnumber signals nearly two to one so the counter hovers near zero and the
  // waiter queue keeps filling; huge releases only come at the end of a phase.
  function automatic in_item_t random_item(input bit allow_big);
    in_item_t it;
    int       pick;
    it.thread_id = 8'($urandom_range(255));
    it.release_count = $urandom;
    pick = $urandom_range(99);
    if (pick < 65) begin
      it.command = OP_WAIT;
    end else begin
      it.command = OP_SIGNAL;
      pick = $urandom_range(99);
      if (pick < 75 || (!allow_big && pick >= 90)) begin
        it.release_count = $urandom_range(1);
      end else if (pick < 90) begin
        it.release_count = $urandom_range(17, 2);
      end else if (pick < 95) begin
        it.release_count = 32'hFFFF_FFFF;
      end
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    if (sent_items < 120 || sent_items >= 200) begin
      while ($urandom_range(99) < 25) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    sent_items++;
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_outstanding != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_initial_count(input logic [31:0] value);
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic run_phase(input logic [31:0] value, input int n);
    drain_replies();
    load_initial_count(value);
    for (int k = 0; k < n; k++) begin
      send_item(random_item(k >= n - 15));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    load_initial_count(32'd0);

    send_item(make_item(OP_SIGNAL, 8'h00, 32'd0));
    send_item(make_item(OP_WAIT, 8'h00, 32'hFFFF_FFFF));
    send_item(make_item(OP_WAIT, 8'hFF, 32'd0));
    send_item(make_item(OP_SIGNAL, 8'h00, 32'd1));
    send_item(make_item(OP_SIGNAL, 8'hFF, 32'hFFFF_FFFF));
    send_item(make_item(OP_SIGNAL, 8'h00, 32'd5));
    send_item(make_item(OP_WAIT, 8'h5A, 32'd0));
    drain_replies();

    // Sixteen waiters fill the queue, the next one is turned away, and one
    // signal then wakes them all and credits the remainder to the counter.
    load_initial_count(32'd0);
    for (int i = 0; i < 17; i++) begin
      send_item(make_item(OP_WAIT, 8'(i * 15), 32'd0));
    end
    send_item(make_item(OP_SIGNAL, 8'h00, 32'd20));

    run_phase(32'd0, 150);
    run_phase(32'd2, 150);
    run_phase(32'hFFFF_FFFF, 60);
    run_phase($urandom, 40);
    run_phase(32'd1, 100);
    drain_replies();

    if (fail_count == 0 && replies_outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/csfw_pkg.sv
hdl/csfw_front.sv
hdl/csfw_queue.sv
hdl/csfw_back.sv
hdl/counting_semaphore_fifo_waiters_top.sv
tb/sv/semaphore_checker.sv
tb/sv/tb_counting_semaphore_fifo_waiters_top.sv
